// File: rtl/core/bci_pkg.sv
// Shared types and constants for the bilinear cell interpolator.
// Stands alone; the core module refers to it by scoped names.
package bci_pkg;

    // Item operations
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_MIN_X        = 3'd0,
        CFG_MIN_Y        = 3'd1,
        CFG_INV_DX       = 3'd2,
        CFG_INV_DY       = 3'd3,
        CFG_GRID_COLUMNS = 3'd4,
        CFG_GRID_ROWS    = 3'd5
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int COORD_W     = 32;
    localparam int GRID_W      = 7;

    // Register reset values
    localparam logic signed [COORD_W-1:0] RST_MIN        = '0;
    localparam logic [COORD_W-1:0]        RST_INV        = 32'h0001_0000;
    localparam logic [GRID_W-1:0]         RST_GRID_COUNT = 7'd64;

endpackage

// File: rtl/core/bilinear_cell_interpolator.sv
// Bilinear interpolation over a uniform grid of cells, fixed point.
// Depends on bci_pkg for opcodes, register indexes and reset values.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  s_      | in        | s_valid / s_ready  | opcode, cell_index, corner, coeff, x, y
//  m_      | out       | m_valid / m_ready  | value, out_of_range
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// One transaction per cycle while the output is not stalled; a query's result reaches m_valid
// through nine register stages, the output register last. Four coefficient banks, one per
// corner, each can take a write and a read together. Loads write a bank and give no result.
// Reset (aresetn, synchronous, active low) clears the valid bits and the configuration
// registers; the coefficient banks are not cleared and hold garbage until loaded.
// Stalls are elastic: bubbles close up, s_ready drops only with every stage full.
module bilinear_cell_interpolator #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64,
    parameter int COEF_WIDTH  = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_opcode,
    input  logic [11:0]                        s_cell_index,
    input  logic [1:0]                         s_corner,
    input  logic signed [31:0]                 s_coeff_value,
    input  logic signed [31:0]                 s_x_coord,
    input  logic signed [31:0]                 s_y_coord,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [31:0]                 m_value,
    output logic                               m_out_of_range,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bci_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bci_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int NUM_STAGES = 9;
    localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
    localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int CX_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CY_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W      = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W      = $clog2(MAX_ROWS + 1);
    localparam int ADDR_CALC_W = CY_W + COL_W + 1;
    // Only the low 32 bits of a coefficient are ever kept
    localparam int STORE_W    = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;
    localparam int PROD_W     = STORE_W + FRAC_BITS + 2;
    localparam int SUM_W      = PROD_W + 1;
    localparam int DIFF_W     = bci_pkg::COORD_W + 1;
    localparam int SCALED_W   = 2 * bci_pkg::COORD_W;
    localparam int CELL_W     = SCALED_W - 2 * FRAC_BITS;

    localparam logic [FRAC_BITS:0]      ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [SUM_W-1:0] HALF_Q = SUM_W'(1) <<< (FRAC_BITS - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [bci_pkg::COORD_W-1:0] min_x_reg, min_y_reg;
    logic [bci_pkg::COORD_W-1:0]        inv_dx_reg, inv_dy_reg;
    logic [bci_pkg::GRID_W-1:0]         grid_columns_reg, grid_rows_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg        <= bci_pkg::RST_MIN;
            min_y_reg        <= bci_pkg::RST_MIN;
            inv_dx_reg       <= bci_pkg::RST_INV;
            inv_dy_reg       <= bci_pkg::RST_INV;
            grid_columns_reg <= bci_pkg::RST_GRID_COUNT;
            grid_rows_reg    <= bci_pkg::RST_GRID_COUNT;
        end else if (cfg_valid) begin
            case (cfg_index)
                bci_pkg::CFG_MIN_X:        min_x_reg        <= $signed(cfg_data);
                bci_pkg::CFG_MIN_Y:        min_y_reg        <= $signed(cfg_data);
                bci_pkg::CFG_INV_DX:       inv_dx_reg       <= cfg_data;
                bci_pkg::CFG_INV_DY:       inv_dy_reg       <= cfg_data;
                bci_pkg::CFG_GRID_COLUMNS: grid_columns_reg <= cfg_data[bci_pkg::GRID_W-1:0];
                bci_pkg::CFG_GRID_ROWS:    grid_rows_reg    <= cfg_data[bci_pkg::GRID_W-1:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // Grid size in use, clamped to what the banks hold
    logic [COL_W-1:0] cols_eff;
    logic [ROW_W-1:0] rows_eff;

    assign cols_eff = (32'(grid_columns_reg) > 32'(MAX_COLUMNS)) ?
                      COL_W'(MAX_COLUMNS) : COL_W'(grid_columns_reg);
    assign rows_eff = (32'(grid_rows_reg) > 32'(MAX_ROWS)) ?
                      ROW_W'(MAX_ROWS) : ROW_W'(grid_rows_reg);

    // ------------------------------------------------------------------
    // Pipeline control: per-stage valid, elastic advance
    // stage_ld[k] high means stage k captures from stage k-1 this cycle.
    // ------------------------------------------------------------------
    logic [NUM_STAGES:1]   valid_reg, valid_next;
    logic [NUM_STAGES+1:1] stage_ld;
    logic                  s4_op_reg;

    always_comb begin
        stage_ld[NUM_STAGES+1] = m_ready;
        for (int k = NUM_STAGES; k >= 1; k--) begin
            stage_ld[k] = !valid_reg[k] || stage_ld[k+1];
        end
    end

    always_comb begin
        for (int k = 1; k <= NUM_STAGES; k++) begin
            valid_next[k] = valid_reg[k];
            if (stage_ld[k]) begin
                if (k == 1) begin
                    valid_next[k] = s_valid;
                end else if (k == 5) begin
                    // loads retire into the banks and stop here
                    valid_next[k] = valid_reg[4] && (s4_op_reg == bci_pkg::OP_QUERY);
                end else begin
                    valid_next[k] = valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_ld[1];
    assign m_valid = valid_reg[NUM_STAGES];

    // ------------------------------------------------------------------
    // Stage 1: offsets from the origin, load address check
    // ------------------------------------------------------------------
    logic                        s1_op_reg, s1_ld_ok_reg;
    logic [CELL_AW-1:0]          s1_ld_addr_reg;
    logic [1:0]                  s1_corner_reg;
    logic [STORE_W-1:0]          s1_coeff_reg;
    logic signed [DIFF_W-1:0]    s1_dx_reg, s1_dy_reg;
    logic signed [DIFF_W-1:0]    s1_dx_next, s1_dy_next;

    assign s1_dx_next = DIFF_W'(s_x_coord) - DIFF_W'(min_x_reg);
    assign s1_dy_next = DIFF_W'(s_y_coord) - DIFF_W'(min_y_reg);

    always_ff @(posedge aclk) begin
        if (stage_ld[1]) begin
            s1_op_reg      <= s_opcode;
            s1_ld_ok_reg   <= 32'(s_cell_index) < 32'(CELL_COUNT);
            s1_ld_addr_reg <= CELL_AW'(s_cell_index);
            s1_corner_reg  <= s_corner;
            s1_coeff_reg   <= s_coeff_value[STORE_W-1:0];
            s1_dx_reg      <= s1_dx_next;
            s1_dy_reg      <= s1_dy_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scale by the reciprocal spacing (32x32 per axis)
    // ------------------------------------------------------------------
    logic                        s2_op_reg, s2_ld_ok_reg;
    logic [CELL_AW-1:0]          s2_ld_addr_reg;
    logic [1:0]                  s2_corner_reg;
    logic [STORE_W-1:0]          s2_coeff_reg;
    logic                        s2_neg_x_reg, s2_neg_y_reg;
    logic [SCALED_W-1:0]         s2_px_reg, s2_py_reg;
    logic [SCALED_W-1:0]         s2_px_next, s2_py_next;

    assign s2_px_next = SCALED_W'(s1_dx_reg[DIFF_W-2:0]) * SCALED_W'(inv_dx_reg);
    assign s2_py_next = SCALED_W'(s1_dy_reg[DIFF_W-2:0]) * SCALED_W'(inv_dy_reg);

    always_ff @(posedge aclk) begin
        if (stage_ld[2]) begin
            s2_op_reg      <= s1_op_reg;
            s2_ld_ok_reg   <= s1_ld_ok_reg;
            s2_ld_addr_reg <= s1_ld_addr_reg;
            s2_corner_reg  <= s1_corner_reg;
            s2_coeff_reg   <= s1_coeff_reg;
            s2_neg_x_reg   <= s1_dx_reg[DIFF_W-1];
            s2_neg_y_reg   <= s1_dy_reg[DIFF_W-1];
            s2_px_reg      <= s2_px_next;
            s2_py_reg      <= s2_py_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: split into cell and fraction, range check
    // ------------------------------------------------------------------
    logic                        s3_op_reg, s3_ld_ok_reg;
    logic [CELL_AW-1:0]          s3_ld_addr_reg;
    logic [1:0]                  s3_corner_reg;
    logic [STORE_W-1:0]          s3_coeff_reg;
    logic [FRAC_BITS-1:0]        s3_fx_reg, s3_fy_reg;
    logic [CX_W-1:0]             s3_cx_reg;
    logic [CY_W-1:0]             s3_cy_reg;
    logic                        s3_oor_reg, s3_oor_next;
    logic [CELL_W-1:0]           cell_x, cell_y;

    assign cell_x = s2_px_reg[SCALED_W-1:2*FRAC_BITS];
    assign cell_y = s2_py_reg[SCALED_W-1:2*FRAC_BITS];

    // a point on the far edge lands in cell == count and is outside
    assign s3_oor_next = s2_neg_x_reg || s2_neg_y_reg
                      || (SCALED_W'(cell_x) >= SCALED_W'(cols_eff))
                      || (SCALED_W'(cell_y) >= SCALED_W'(rows_eff));

    always_ff @(posedge aclk) begin
        if (stage_ld[3]) begin
            s3_op_reg      <= s2_op_reg;
            s3_ld_ok_reg   <= s2_ld_ok_reg;
            s3_ld_addr_reg <= s2_ld_addr_reg;
            s3_corner_reg  <= s2_corner_reg;
            s3_coeff_reg   <= s2_coeff_reg;
            s3_fx_reg      <= s2_px_reg[2*FRAC_BITS-1:FRAC_BITS];
            s3_fy_reg      <= s2_py_reg[2*FRAC_BITS-1:FRAC_BITS];
            s3_cx_reg      <= CX_W'(cell_x);
            s3_cy_reg      <= CY_W'(cell_y);
            s3_oor_reg     <= s3_oor_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: bank address (cell of a query, or load target)
    // ------------------------------------------------------------------
    logic                        s4_ld_ok_reg;
    logic [1:0]                  s4_corner_reg;
    logic [STORE_W-1:0]          s4_coeff_reg;
    logic [CELL_AW-1:0]          s4_addr_reg, s4_addr_next;
    logic [FRAC_BITS-1:0]        s4_fx_reg, s4_fy_reg;
    logic                        s4_oor_reg;

    assign s4_addr_next = (s3_op_reg == bci_pkg::OP_QUERY) ?
        CELL_AW'(ADDR_CALC_W'(s3_cy_reg) * ADDR_CALC_W'(cols_eff)
                 + ADDR_CALC_W'(s3_cx_reg)) :
        s3_ld_addr_reg;

    always_ff @(posedge aclk) begin
        if (stage_ld[4]) begin
            s4_op_reg     <= s3_op_reg;
            s4_ld_ok_reg  <= s3_ld_ok_reg;
            s4_corner_reg <= s3_corner_reg;
            s4_coeff_reg  <= s3_coeff_reg;
            s4_addr_reg   <= s4_addr_next;
            s4_fx_reg     <= s3_fx_reg;
            s4_fy_reg     <= s3_fy_reg;
            s4_oor_reg    <= s3_oor_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: coefficient banks, one per corner. A load writes one bank
    // as it leaves stage 4; a query reads all four at once. Items stay in
    // order, so a load always lands before any later query reads.
    // ------------------------------------------------------------------
    logic signed [STORE_W-1:0]   s5_coef_reg [4];
    logic [3:0]                  bank_we;
    logic [FRAC_BITS-1:0]        s5_fx_reg, s5_fy_reg;
    logic                        s5_oor_reg;

    always_comb begin
        for (int g = 0; g < 4; g++) begin
            bank_we[g] = stage_ld[5] && valid_reg[4] && (s4_op_reg == bci_pkg::OP_LOAD)
                      && s4_ld_ok_reg && (s4_corner_reg == 2'(g));
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        logic [STORE_W-1:0] mem [CELL_COUNT];

        always_ff @(posedge aclk) begin
            if (bank_we[g]) begin
                mem[s4_addr_reg] <= s4_coeff_reg;
            end
            if (stage_ld[5]) begin
                s5_coef_reg[g] <= $signed(mem[s4_addr_reg]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ld[5]) begin
            s5_fx_reg  <= s4_fx_reg;
            s5_fy_reg  <= s4_fy_reg;
            s5_oor_reg <= s4_oor_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: x-direction weights times corners
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0]    s6_prod_reg [4];
    logic signed [PROD_W-1:0]    s6_prod_next [4];
    logic signed [PROD_W-1:0]    wx_lo, wx_hi;
    logic [FRAC_BITS-1:0]        s6_fy_reg;
    logic                        s6_oor_reg;

    assign wx_lo = PROD_W'(ONE_Q - {1'b0, s5_fx_reg});
    assign wx_hi = PROD_W'(s5_fx_reg);

    always_comb begin
        for (int g = 0; g < 4; g++) begin
            s6_prod_next[g] = PROD_W'(s5_coef_reg[g]) * (g[0] ? wx_hi : wx_lo);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ld[6]) begin
            s6_prod_reg <= s6_prod_next;
            s6_fy_reg   <= s5_fy_reg;
            s6_oor_reg  <= s5_oor_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: round the two x blends (half up)
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]     sum_a0, sum_a1;
    logic signed [STORE_W-1:0]   s7_a0_reg, s7_a1_reg;
    logic [FRAC_BITS-1:0]        s7_fy_reg;
    logic                        s7_oor_reg;

    assign sum_a0 = SUM_W'(s6_prod_reg[0]) + SUM_W'(s6_prod_reg[1]) + HALF_Q;
    assign sum_a1 = SUM_W'(s6_prod_reg[2]) + SUM_W'(s6_prod_reg[3]) + HALF_Q;

    always_ff @(posedge aclk) begin
        if (stage_ld[7]) begin
            s7_a0_reg  <= STORE_W'(sum_a0 >>> FRAC_BITS);
            s7_a1_reg  <= STORE_W'(sum_a1 >>> FRAC_BITS);
            s7_fy_reg  <= s6_fy_reg;
            s7_oor_reg <= s6_oor_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: y-direction weights
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0]    wy_lo, wy_hi;
    logic signed [PROD_W-1:0]    s8_p0_reg, s8_p1_reg;
    logic                        s8_oor_reg;

    assign wy_lo = PROD_W'(ONE_Q - {1'b0, s7_fy_reg});
    assign wy_hi = PROD_W'(s7_fy_reg);

    always_ff @(posedge aclk) begin
        if (stage_ld[8]) begin
            s8_p0_reg  <= PROD_W'(s7_a0_reg) * wy_lo;
            s8_p1_reg  <= PROD_W'(s7_a1_reg) * wy_hi;
            s8_oor_reg <= s7_oor_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: final rounding into the output register
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]     sum_v;
    logic signed [STORE_W-1:0]   blend_v;
    logic signed [31:0]          m_value_reg, m_value_next;
    logic                        m_oor_reg;

    assign sum_v        = SUM_W'(s8_p0_reg) + SUM_W'(s8_p1_reg) + HALF_Q;
    assign blend_v      = STORE_W'(sum_v >>> FRAC_BITS);
    assign m_value_next = s8_oor_reg ? '0 : 32'(blend_v);

    always_ff @(posedge aclk) begin
        if (stage_ld[9]) begin
            m_value_reg <= m_value_next;
            m_oor_reg   <= s8_oor_reg;
        end
    end

    assign m_value        = m_value_reg;
    assign m_out_of_range = m_oor_reg;

endmodule

// File: tb/bilinear_cell_interpolator_test.sv
// Self-checking testbench for bilinear_cell_interpolator: coefficient loads and point queries.
// A bit-accurate predictor checks every result. Needs only bci_pkg and the core module.
module bilinear_cell_interpolator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLS      = 64;
    localparam int MAX_ROWS      = 64;
    localparam int STORE_DEPTH   = MAX_COLS * MAX_ROWS * 4;
    localparam int SETTLE_CYCLES = 24;   // pipeline is 9 deep, leave margin for loads
    localparam int HOLD_CYCLES   = 300;  // long back-pressure stretch
    localparam longint ONE_Q16   = 64'sd65536;
    localparam longint HALF_Q16  = 64'sd32768;
    localparam longint COORD_MAX = 64'sd2147483647;

    // One input transaction as queued for the driver
    typedef struct packed {
        logic        opcode;
        logic [11:0] cell_index;
        logic [1:0]  corner;
        logic [31:0] coeff;
        logic [31:0] x;
        logic [31:0] y;
    } request_t;

    // One expected output transaction
    typedef struct packed {
        logic [31:0] value;
        logic        out_of_range;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = bci_pkg::OP_LOAD;
    logic [11:0] s_cell_index = '0;
    logic [1:0]  s_corner = '0;
    logic signed [31:0] s_coeff_value = '0;
    logic signed [31:0] s_x_coord = '0;
    logic signed [31:0] s_y_coord = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_value;
    logic        m_out_of_range;

    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bci_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bci_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Predictor state: register copy and coefficient store
    logic signed [31:0] org_x   = bci_pkg::RST_MIN;
    logic signed [31:0] org_y   = bci_pkg::RST_MIN;
    logic [31:0]        scale_x = bci_pkg::RST_INV;
    logic [31:0]        scale_y = bci_pkg::RST_INV;
    logic [6:0]         cols_reg = bci_pkg::RST_GRID_COUNT;
    logic [6:0]         rows_reg = bci_pkg::RST_GRID_COUNT;
    logic signed [31:0] coef_copy [0:STORE_DEPTH-1];

    // Generator bookkeeping: which store entries have a load queued ahead
    bit coef_planned [0:STORE_DEPTH-1];

    request_t outbound_q[$];   // transactions waiting for the driver
    result_t  interp_q[$];     // predicted results, oldest first
    request_t on_bus;          // transaction currently offered on s_

    int pushed_items   = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    logic sink_hold = 1'b0;

    bilinear_cell_interpolator #(
        .MAX_COLUMNS (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS),
        .COEF_WIDTH  (32),
        .FRAC_BITS   (16)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_cell_index   (s_cell_index),
        .s_corner       (s_corner),
        .s_coeff_value  (s_coeff_value),
        .s_x_coord      (s_x_coord),
        .s_y_coord      (s_y_coord),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value        (m_value),
        .m_out_of_range (m_out_of_range),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Columns/rows register above the array size acts as the array size
    function automatic int unsigned eff_count(logic [6:0] r, int unsigned cap);
        return (r > cap) ? cap : r;
    endfunction

    // One axis: offset from origin times reciprocal spacing, exact 64-bit
    // product with 32 fraction bits. Integer part is the cell, the next 16
    // bits the position inside it. Below origin or past the last cell: out.
    function automatic bit locate_axis(logic signed [31:0] coord, logic signed [31:0] origin,
                                       logic [31:0] inv, int unsigned limit,
                                       output logic [31:0] cell_no, output logic [15:0] frac);
        longint      offset;
        logic [63:0] prod;
        offset = longint'(coord) - longint'(origin);
        cell_no = '0;
        frac = '0;
        if (offset < 0)
            return 1'b0;
        prod = {32'b0, offset[31:0]} * {32'b0, inv};
        cell_no = prod[63:32];
        frac = prod[31:16];
        return cell_no < limit;
    endfunction

    // Linear blend with round-half-up back to Q16.16 (floor after adding half)
    function automatic logic [31:0] lerp_q16(longint lo, longint hi, longint f);
        longint acc;
        acc = lo * (ONE_Q16 - f) + hi * f + HALF_Q16;
        acc = acc >>> 16;
        return acc[31:0];
    endfunction

    // Accepted transaction: a load updates the store copy, a query yields
    // one predicted result
    function automatic void absorb_item(request_t it);
        logic [31:0]  cx, cy;
        logic [15:0]  fx, fy;
        int unsigned  cols_n, rows_n, base;
        logic [31:0]  top, bottom;
        result_t      r;
        if (it.opcode == bci_pkg::OP_LOAD) begin
            coef_copy[{it.cell_index, it.corner}] = it.coeff;
            return;
        end
        cols_n = eff_count(cols_reg, MAX_COLS);
        rows_n = eff_count(rows_reg, MAX_ROWS);
        if (!locate_axis(it.x, org_x, scale_x, cols_n, cx, fx) ||
            !locate_axis(it.y, org_y, scale_y, rows_n, cy, fy)) begin
            r.value = '0;
            r.out_of_range = 1'b1;
        end else begin
            base = (cy * cols_n + cx) * 4;
            // x first along both edges of the cell, then y between them
            bottom = lerp_q16(coef_copy[base], coef_copy[base + 1], fx);
            top    = lerp_q16(coef_copy[base + 2], coef_copy[base + 3], fx);
            r.value = lerp_q16($signed(bottom), $signed(top), fy);
            r.out_of_range = 1'b0;
        end
        interp_q.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [31:0] rand_coeff();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a small hot corner of the grid so cells get reused
    function automatic int unsigned pick_cell(int unsigned n);
        if (n == 0)
            return 0;
        if (n > 4 && $urandom_range(99) < 60)
            return $urandom_range(3);
        return $urandom_range(n - 1);
    endfunction

    // Coordinate that lands at (cell + frac) along an axis, clamped to the
    // signed range. Clamping or rounding may move it; the predictor decides.
    function automatic logic [31:0] aim_coord(logic signed [31:0] origin, logic [31:0] inv,
                                              longint cell_no, longint frac);
        longint span, c;
        if (inv == 0)
            span = longint'($urandom);
        else
            span = ((cell_no << 32) + (frac << 16) + longint'(inv) - 1) / longint'(inv);
        c = longint'(origin) + span;
        if (c > COORD_MAX)
            c = COORD_MAX;
        return c[31:0];
    endfunction

    task automatic push_load(logic [11:0] idx, logic [1:0] corner, logic [31:0] coeff);
        request_t it;
        it.opcode     = bci_pkg::OP_LOAD;
        it.cell_index = idx;
        it.corner     = corner;
        it.coeff      = coeff;
        it.x          = $urandom;
        it.y          = $urandom;
        outbound_q.push_back(it);
        coef_planned[{idx, corner}] = 1'b1;
        pushed_items++;
    endtask

    // A query into a cell not fully loaded gets the missing loads ahead of it
    task automatic push_query(logic [31:0] qx, logic [31:0] qy);
        request_t    it;
        logic [31:0] cx, cy;
        logic [15:0] fx, fy;
        int unsigned cols_n, rows_n, cell_no;
        cols_n = eff_count(cols_reg, MAX_COLS);
        rows_n = eff_count(rows_reg, MAX_ROWS);
        if (locate_axis(qx, org_x, scale_x, cols_n, cx, fx) &&
            locate_axis(qy, org_y, scale_y, rows_n, cy, fy)) begin
            cell_no = cy * cols_n + cx;
            for (int c = 0; c < 4; c++) begin
                if (!coef_planned[cell_no * 4 + c])
                    push_load(cell_no[11:0], c[1:0], rand_coeff());
            end
        end
        it.opcode     = bci_pkg::OP_QUERY;
        it.cell_index = 12'($urandom);
        it.corner     = 2'($urandom);
        it.coeff      = $urandom;
        it.x          = qx;
        it.y          = qy;
        outbound_q.push_back(it);
        pushed_items++;
    endtask

    // Random mix: a quarter loads, the rest queries. Queries mostly aim
    // inside the grid; some are wild, just below origin, or on the far edge.
    task automatic queue_random_items(int count);
        int          start, pick;
        int unsigned cols_n, rows_n, cell_no;
        logic [31:0] qx, qy;
        start  = pushed_items;
        cols_n = eff_count(cols_reg, MAX_COLS);
        rows_n = eff_count(rows_reg, MAX_ROWS);
        while (pushed_items - start < count) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                if ($urandom_range(1)) begin
                    cell_no = pick_cell(rows_n) * cols_n + pick_cell(cols_n);
                    push_load(cell_no[11:0], 2'($urandom), rand_coeff());
                end else begin
                    push_load(12'($urandom), 2'($urandom), rand_coeff());
                end
            end else begin
                qx = aim_coord(org_x, scale_x, pick_cell(cols_n), $urandom_range(65535));
                qy = aim_coord(org_y, scale_y, pick_cell(rows_n), $urandom_range(65535));
                if (pick >= 80 && pick < 88) begin
                    qx = $urandom;
                    qy = $urandom;
                end else if (pick >= 88 && pick < 94) begin
                    if ($urandom_range(1))
                        qx = org_x - 1;
                    else
                        qy = org_y - 1;
                end else if (pick >= 94) begin
                    if ($urandom_range(1))
                        qx = aim_coord(org_x, scale_x, cols_n, 0);
                    else
                        qy = aim_coord(org_y, scale_y, rows_n, 0);
                end
                push_query(qx, qy);
            end
        end
    endtask

    // Register write over the cfg_ channel; the predictor's copy follows
    task automatic write_reg(bci_pkg::cfg_index_t idx, logic [31:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            bci_pkg::CFG_MIN_X:        org_x    = data;
            bci_pkg::CFG_MIN_Y:        org_y    = data;
            bci_pkg::CFG_INV_DX:       scale_x  = data;
            bci_pkg::CFG_INV_DY:       scale_y  = data;
            bci_pkg::CFG_GRID_COLUMNS: cols_reg = data[6:0];
            bci_pkg::CFG_GRID_ROWS:    rows_reg = data[6:0];
            default: ;
        endcase
    endtask

    task automatic program_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] ix,
                                logic [31:0] iy, logic [31:0] ncols, logic [31:0] nrows);
        write_reg(bci_pkg::CFG_MIN_X, ox);
        write_reg(bci_pkg::CFG_MIN_Y, oy);
        write_reg(bci_pkg::CFG_INV_DX, ix);
        write_reg(bci_pkg::CFG_INV_DY, iy);
        write_reg(bci_pkg::CFG_GRID_COLUMNS, ncols);
        write_reg(bci_pkg::CFG_GRID_ROWS, nrows);
        @(negedge aclk);
    endtask

    // Sender pause: nothing queued or offered and every result back, then
    // a settle wait of SETTLE_CYCLES so trailing loads leave the pipeline
    task automatic wait_drained();
        do @(negedge aclk);
        while (outbound_q.size() != 0 || s_valid || interp_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued transactions on s_, predicts on acceptance.
    // Valid is held with a stable payload until the transaction goes through.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                absorb_item(on_bus);
            if (!s_valid || s_ready) begin
                if (outbound_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = outbound_q.pop_front();
                    s_opcode      <= on_bus.opcode;
                    s_cell_index  <= on_bus.cell_index;
                    s_corner      <= on_bus.corner;
                    s_coeff_value <= on_bus.coeff;
                    s_x_coord     <= on_bus.x;
                    s_y_coord     <= on_bus.y;
                    s_valid       <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transaction against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (interp_q.size() == 0) begin
                    report_mismatch($sformatf("result with none pending: value %h oor %b",
                                              m_value, m_out_of_range));
                end else begin
                    want = interp_q.pop_front();
                    if (m_value !== want.value)
                        report_mismatch($sformatf("result %0d value %h, predicted %h",
                                                  results_seen, m_value, want.value));
                    if (m_out_of_range !== want.out_of_range)
                        report_mismatch($sformatf("result %0d out_of_range %b, predicted %b",
                                                  results_seen, m_out_of_range,
                                                  want.out_of_range));
                end
            end
            m_ready <= !sink_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long back-pressure once traffic is flowing: the pipeline fills and
    // s_ready must drop while the driver keeps offering
    initial begin
        wait (results_seen >= 60);
        @(posedge aclk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial begin
        aresetn = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, reset register values: unit grid at the origin, 64 x 64
        send_idle_pct = 6;
        recv_idle_pct = 69;
        push_load(12'd0, 2'd0, 32'h8000_0000);
        push_load(12'd0, 2'd1, 32'h7FFF_FFFF);
        push_load(12'd0, 2'd2, 32'h0000_0000);
        push_load(12'd0, 2'd3, 32'hFFFF_FFFF);
        push_load(12'd4095, 2'd3, 32'hFFFF_0000);
        push_load(12'd4095, 2'd2, 32'h0001_8000);
        push_load(12'd4095, 2'd1, 32'h8000_0000);
        push_load(12'd4095, 2'd0, 32'h7FFF_FFFF);
        push_query(32'h0000_0000, 32'h0000_0000);    // cell corner, zero fraction
        push_query(32'h0000_8000, 32'h0000_8000);    // cell center
        push_query(32'h0000_FFFF, 32'h0000_FFFF);    // largest fraction
        push_query(32'h003F_FFFF, 32'h003F_FFFF);    // last cell of the grid
        push_query(32'h0040_0000, 32'h0000_0000);    // on the far x edge: outside
        push_query(32'h0000_0000, 32'h0040_0000);    // on the far y edge: outside
        push_query(32'hFFFF_FFFF, 32'h0000_0000);    // just below origin in x
        push_query(32'h0000_0000, 32'hFFFF_FFFF);    // just below origin in y
        push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_query(32'h8000_0000, 32'h8000_0000);
        wait_drained();

        // Offset origin, half-unit x cells, 12 columns; rows written with
        // stray upper bits (low seven give 9)
        program_grid(32'hFFFC_8000, 32'h0002_4000, 32'h0002_0000, 32'h0000_C000,
                     32'd12, 32'h0000_0189);
        queue_random_items(300);
        wait_drained();
        queue_random_items(300);
        wait_drained();

        // Extremes: most negative x origin with the smallest scale, y origin
        // near the top with the largest scale, columns above the array size
        program_grid(32'h8000_0000, 32'h7FFF_FFC0, 32'h0000_0001, 32'hFFFF_FFFF,
                     32'd127, 32'd64);
        send_idle_pct = 69;
        recv_idle_pct = 6;
        queue_random_items(500);
        wait_drained();

        // No idling from here. Zero columns: every query is outside.
        program_grid(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000,
                     32'd0, 32'd5);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_items(40);
        wait_drained();

        // Zero x scale: every x at or above the origin lands at the start of the single column
        program_grid(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h0001_0000,
                     32'd1, 32'd64);
        queue_random_items(100);
        wait_drained();

        // Origin near the top of the range, fine x cells, rows above the array size
        program_grid(32'h7FFF_0000, 32'hC000_0000, 32'h0100_0000, 32'h0000_0800,
                     32'd64, 32'd100);
        queue_random_items(560);
        wait_drained();

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
